FILE: rtl/core/gtlfo_pkg.sv
// Shared types, constants and the sine table for the gate/trigger/LFO source channel.
`default_nettype none

package gtlfo_pkg;

   localparam int PHASE_BITS   = 24;
   localparam int SINE_ENTRIES = 256;
   localparam int PENDING_MAX  = 15;

   localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
   localparam int PEND_BITS    = $clog2(PENDING_MAX + 1);
   localparam int VOLT_BITS    = 16;
   localparam int LEVEL_BITS   = 16;
   localparam int STEP_BITS    = 24;
   localparam int TICK_BITS    = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DAT_BITS = 24;
   localparam int UNIT_BITS    = 18;
   localparam int TAB_BITS     = 17;

   localparam logic signed [VOLT_BITS-1:0] VOLT_TEN = 16'sd20480;
   localparam logic signed [VOLT_BITS-1:0] VOLT_NEG_TEN = -16'sd20480;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      MODE_GATE    = 2'd0,
      MODE_TRIGGER = 2'd1,
      MODE_DC      = 2'd2,
      MODE_WAVE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      WAVE_SIN = 2'd0,
      WAVE_TRI = 2'd1,
      WAVE_SQR = 2'd2,
      WAVE_SAW = 2'd3
   } wave_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLE      = 3'd0,
      CSR_MODE        = 3'd1,
      CSR_WAVEFORM    = 3'd2,
      CSR_LEVEL       = 3'd3,
      CSR_PHASE_STEP  = 3'd4,
      CSR_PULSE_TICKS = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                          enable;
      mode_type                      mode;
      wave_type                      waveform;
      logic signed [LEVEL_BITS-1:0]  level;
      logic [STEP_BITS-1:0]          phase_step;
      logic [TICK_BITS-1:0]          pulse_ticks;
   } cfg_type;

   // Word handed from the state stage to the waveform stage.
   typedef struct packed {
      logic                          driven;
      logic                          is_wave;
      logic signed [VOLT_BITS-1:0]   volt;
      logic [PHASE_BITS-1:0]         phase;
      wave_type                      waveform;
      logic signed [LEVEL_BITS-1:0]  level;
   } stage_type;

   typedef logic [TAB_BITS-1:0] sine_tab_type [0:SINE_ENTRIES];

   // sin(pi/2 * k/N) in Q16 from a truncating Q30 Taylor series up to x^15
   function automatic logic [TAB_BITS-1:0] sine_q16(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] s;
      x  = (HALF_PI_Q30 * 64'(k)) / SINE_ENTRIES;
      x2 = (x * x) >> 30;
      t  = x;
      s  = signed'(x);
      t  = ((t * x2) >> 30) / 64'd6;
      s  = s - signed'(t);
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + signed'(t);
      t  = ((t * x2) >> 30) / 64'd42;
      s  = s - signed'(t);
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + signed'(t);
      t  = ((t * x2) >> 30) / 64'd110;
      s  = s - signed'(t);
      t  = ((t * x2) >> 30) / 64'd156;
      s  = s + signed'(t);
      t  = ((t * x2) >> 30) / 64'd210;
      s  = s - signed'(t);
      if (s < 0) begin
         s = 64'sd0;
      end
      s = (s + 64'sd8192) >>> 14;
      if (s > 64'sd65536) begin
         s = 64'sd65536;
      end
      return TAB_BITS'(s);
   endfunction

   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      for (int k = 0; k <= SINE_ENTRIES; k++) begin
         tab[k] = sine_q16(k);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

endpackage

`default_nettype wire

FILE: rtl/core/gate_trigger_lfo_source.sv
// Top level of the gate/trigger/LFO control-voltage source channel.
`default_nettype none

// One control-voltage source channel: each accepted req word is one sample tick and yields
// exactly one rsp word, in order. The block takes a word every cycle while req_stall is low;
// each word is registered first in the state stage, which updates the phase accumulator,
// the trigger pulse counter and the press queue, then in the shaping stage, which reads
// the quarter-wave sine table, forms the unit wave and scales it by the clamped level
// with a single 18x16 multiply. When rsp_stall holds a finished word, the whole
// two-stage pipe freezes and req_stall rises in the same cycle. Voltages are Q4.11
// signed (2048 per volt). With enable low, words come back with voltage zero and driven low,
// and the channel state holds; writing enable from low to high clears the phase, the pulse
// counter and the press queue. Write csr registers only while no word is in flight.
module gate_trigger_lfo_source (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_gate_held,
   input  wire logic                req_trigger_press,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_voltage,
   output logic                     rsp_driven,
   input  wire logic                csr_we,
   input  wire logic [2:0]          csr_index,
   input  wire logic [23:0]         csr_wdata
);
   import gtlfo_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      clear;
   logic      advance;
   logic      stage_valid;
   stage_type stage;

   // Freeze every stage while the result register is held.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Register writes; a rising enable clears the channel state.
   always_comb begin
      cfg_in = cfg_ff;
      clear  = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE: begin
               cfg_in.enable = csr_wdata[0];
               clear         = csr_wdata[0] && !cfg_ff.enable;
            end
            CSR_MODE:        cfg_in.mode        = mode_type'(csr_wdata[1:0]);
            CSR_WAVEFORM:    cfg_in.waveform    = wave_type'(csr_wdata[1:0]);
            CSR_LEVEL:       cfg_in.level       = signed'(csr_wdata[LEVEL_BITS-1:0]);
            CSR_PHASE_STEP:  cfg_in.phase_step  = csr_wdata[STEP_BITS-1:0];
            CSR_PULSE_TICKS: cfg_in.pulse_ticks = csr_wdata[TICK_BITS-1:0];
            default: begin
               // drop writes to unmapped indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable      <= 1'b0;
         cfg_ff.mode        <= MODE_GATE;
         cfg_ff.waveform    <= WAVE_SIN;
         cfg_ff.level       <= 16'sd10240;
         cfg_ff.phase_step  <= 24'd1141;
         cfg_ff.pulse_ticks <= 16'd48;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gtlfo_track u_track (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_valid),
      .gate_held     (req_gate_held),
      .trigger_press (req_trigger_press),
      .clear         (clear),
      .cfg           (cfg_ff),
      .stage_valid   (stage_valid),
      .stage         (stage)
   );

   gtlfo_shape u_shape (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage       (stage),
      .rsp_valid   (rsp_valid),
      .rsp_voltage (rsp_voltage),
      .rsp_driven  (rsp_driven)
   );

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while result word is held");

endmodule

`default_nettype wire

FILE: rtl/core/gtlfo_track.sv
// Channel state (phase, pulse, press queue) and the input stage register.
`default_nettype none

module gtlfo_track (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                req_valid,
   input  wire logic                gate_held,
   input  wire logic                trigger_press,
   input  wire logic                clear,
   input  wire gtlfo_pkg::cfg_type  cfg,
   output logic                     stage_valid,
   output gtlfo_pkg::stage_type     stage
);
   import gtlfo_pkg::*;

   localparam int SUM_BITS = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [TICK_BITS-1:0]  pulse_ff, pulse_in;
   logic [PEND_BITS-1:0]  pend_ff, pend_in;
   logic                  stage_valid_ff;
   stage_type             stage_ff, stage_in;

   logic                  accept;
   logic [SUM_BITS-1:0]   phase_sum;
   logic [PEND_BITS-1:0]  pend_q;
   logic [TICK_BITS-1:0]  pulse_q;
   logic signed [LEVEL_BITS-1:0] level_clamped;

   assign accept = req_valid && advance;

   always_comb begin
      phase_in  = phase_ff;
      pulse_in  = pulse_ff;
      pend_in   = pend_ff;
      phase_sum = SUM_BITS'(phase_ff) + SUM_BITS'(cfg.phase_step);
      pend_q    = pend_ff;
      pulse_q   = pulse_ff;

      if (cfg.level > VOLT_TEN) begin
         level_clamped = VOLT_TEN;
      end else if (cfg.level < VOLT_NEG_TEN) begin
         level_clamped = VOLT_NEG_TEN;
      end else begin
         level_clamped = cfg.level;
      end

      stage_in          = '0;
      stage_in.driven   = cfg.enable;
      stage_in.waveform = cfg.waveform;
      stage_in.level    = level_clamped;
      stage_in.phase    = phase_ff;

      if (cfg.enable) begin
         case (cfg.mode)
            MODE_GATE: begin
               stage_in.volt = gate_held ? VOLT_TEN : '0;
            end
            MODE_TRIGGER: begin
               // queue the press, saturating
               if (trigger_press && (pend_q < PEND_BITS'(PENDING_MAX))) begin
                  pend_q = pend_q + 1'b1;
               end
               // start the next pulse once the last one ends
               if ((pend_q != '0) && (pulse_q == '0)) begin
                  pend_q  = pend_q - 1'b1;
                  pulse_q = (cfg.pulse_ticks != '0) ? cfg.pulse_ticks : TICK_BITS'(1);
               end
               if (pulse_q != '0) begin
                  pulse_q       = pulse_q - 1'b1;
                  stage_in.volt = VOLT_TEN;
               end
               if (accept) begin
                  pend_in  = pend_q;
                  pulse_in = pulse_q;
               end
            end
            MODE_DC: begin
               stage_in.volt = level_clamped;
            end
            default: begin
               stage_in.is_wave = 1'b1;
               stage_in.phase   = PHASE_BITS'(phase_sum);
               if (accept) begin
                  phase_in = PHASE_BITS'(phase_sum);
               end
            end
         endcase
      end

      if (clear) begin
         phase_in = '0;
         pulse_in = '0;
         pend_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         pulse_ff       <= '0;
         pend_ff        <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pulse_ff <= pulse_in;
         pend_ff  <= pend_in;
         if (advance) begin
            stage_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_BITS'(PENDING_MAX))
      else $error("press queue above its limit");

   a_hold_disabled: assert property (@(posedge clock) disable iff (reset)
      (accept && !cfg.enable && !clear) |=> (phase_ff == $past(phase_ff)) &&
                                           (pend_ff == $past(pend_ff)))
      else $error("state moved while channel disabled");

endmodule

`default_nettype wire

FILE: rtl/core/gtlfo_shape.sv
// Waveform shaping, amplitude scaling and the result register.
`default_nettype none

module gtlfo_shape (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  stage_valid,
   input  wire gtlfo_pkg::stage_type  stage,
   output logic                       rsp_valid,
   output logic signed [15:0]         rsp_voltage,
   output logic                       rsp_driven
);
   import gtlfo_pkg::*;

   logic                          valid_ff;
   logic signed [VOLT_BITS-1:0]   volt_ff, volt_in;
   logic                          driven_ff;

   logic [31:0]                   p32;
   logic [15:0]                   p16;
   logic [1:0]                    quad;
   logic [SINE_BITS:0]            idx;
   logic [SINE_BITS:0]            addr;
   logic [TAB_BITS-1:0]           mag_tab;
   logic signed [19:0]            wide;
   logic signed [UNIT_BITS-1:0]   unit;
   logic signed [33:0]            prod;
   logic [32:0]                   mag;
   logic [16:0]                   rnd;

   always_comb begin
      p32     = 32'(stage.phase) << (32 - PHASE_BITS);
      p16     = p32[31:16];
      quad    = p32[31:30];
      idx     = {1'b0, p32[29 -: SINE_BITS]};
      addr    = quad[0] ? ((SINE_BITS+1)'(SINE_ENTRIES) - idx) : idx;
      mag_tab = SINE_TAB[addr];
      wide    = '0;

      case (stage.waveform)
         WAVE_TRI: begin
            if (!p16[15]) begin
               wide = signed'(20'({p16, 2'b00})) - 20'sd65536;
            end else begin
               wide = 20'sd196608 - signed'(20'({p16, 2'b00}));
            end
         end
         WAVE_SQR: begin
            wide = p16[15] ? -20'sd65536 : 20'sd65536;
         end
         WAVE_SAW: begin
            wide = signed'(20'({p16, 1'b0})) - 20'sd65536;
         end
         default: begin
            wide = quad[1] ? -signed'(20'(mag_tab)) : signed'(20'(mag_tab));
         end
      endcase
      unit = UNIT_BITS'(wide);

      // round half away from zero
      prod = unit * stage.level;
      mag  = prod[33] ? 33'(-prod) : prod[32:0];
      rnd  = 17'((mag + 33'd32768) >> 16);

      if (!stage.driven) begin
         volt_in = '0;
      end else if (stage.is_wave) begin
         volt_in = prod[33] ? -signed'(VOLT_BITS'(rnd)) : signed'(VOLT_BITS'(rnd));
      end else begin
         volt_in = stage.volt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_valid) begin
         volt_ff   <= volt_in;
         driven_ff <= stage.driven;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_voltage = volt_ff;
   assign rsp_driven  = driven_ff;

   a_undriven_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !driven_ff) |-> (volt_ff == '0))
      else $error("undriven word with nonzero voltage");

   a_volt_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((volt_ff <= VOLT_TEN) && (volt_ff >= VOLT_NEG_TEN)))
      else $error("voltage outside plus or minus ten volts");

endmodule

`default_nettype wire
